@@ sv/max_priority_queue_assert.svh @@
// Assertion macros for the priority queue RTL.
`ifndef MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define MPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mpq_pkg.sv @@
// Types and constants shared by the priority queue cells and the top level.
package mpq_pkg;

    // Operation codes carried on the mode input.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Value reported as the largest key while the store is empty.
    localparam logic signed [31:0] EMPTY_TOP = -32'sd1;

    // What one cell shows to its two neighbours.
    typedef struct packed {
        logic               valid;
        logic               keep;
        logic signed [31:0] value;
    } t_cell_link;

    // Beyond the head: always keeps, so the first cell that gives way takes the key.
    localparam t_cell_link LINK_HEAD = '{valid: 1'b1, keep: 1'b1, value: 32'sd0};
    // Beyond the tail: empty, so a remove shifts an empty slot into the last cell.
    localparam t_cell_link LINK_TAIL = '{valid: 1'b0, keep: 1'b0, value: 32'sd0};

endpackage

@@ sv/mpq_cell.sv @@
// One slot of the sorted store: holds a key and moves it along the chain.
module mpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ins,
    input  logic                i_rem,
    input  logic signed [31:0]  i_key,
    input  mpq_pkg::t_cell_link i_left,
    input  mpq_pkg::t_cell_link i_right,
    output mpq_pkg::t_cell_link o_link
);
    import mpq_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               w_keep;

    // A slot stays put on insert when its key is not below the new one, so equal keys
    // keep arrival order.
    assign w_keep = r_valid && (r_value >= i_key);
    assign o_link = '{valid: r_valid, keep: w_keep, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        priority if (i_ins) begin
            if (!w_keep) begin
                if (i_left.keep) begin
                    n_valid = 1'b1;
                    n_value = i_key;
                end else begin
                    n_valid = i_left.valid;
                    n_value = i_left.value;
                end
            end
        end else if (i_rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else begin
            n_valid = r_valid;
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ sv/max_priority_queue.sv @@
// Top level of the bounded max priority queue built as a chain of sorting cells.
//
// The queue holds up to DEPTH signed 32-bit keys in descending order in a row of
// cells, the largest in the first cell. A beat on the command side is taken at a
// rising edge where start is high and busy is low; busy never rises, so a beat may
// be issued in every cycle. Mode 0 inserts the key behind any equal keys already
// stored; mode 1 removes the largest key and does nothing on an empty store. The
// key is broadcast to every cell, each cell compares it with its own key and either
// holds, takes the key, or takes its neighbour's key, so the whole store settles
// through that single compare per cell. In the cycle after each accepted beat
// o_done is high for exactly one cycle with the result: the largest key (-1 when
// empty), the empty flag, the low five bits of the count, and an overflow flag set
// when an insert was dropped because the store was full. The receiver cannot hold
// results off: it must take each one in the cycle it is shown. Nothing needs
// clearing after reset beyond the cell valid flags, count, done and overflow flags.
module max_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic signed [31:0] o_top_value,
    output logic               o_is_empty,
    output logic [4:0]         o_entry_count,
    output logic               o_overflow
);
    import mpq_pkg::*;

    localparam int CountW = $clog2(DEPTH + 1);

    logic              w_accept;
    logic              w_full;
    logic              w_ins;
    logic              w_rem;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              r_done;
    logic              r_overflow;
    logic [31:0]       w_count_wide;
    logic [DEPTH-1:0]  w_valid_vec;
    t_cell_link        w_link [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CountW'(DEPTH));

    // A full store drops the insert; an empty store ignores the remove.
    assign w_ins = w_accept && (i_mode == MODE_INSERT) && !w_full;
    assign w_rem = w_accept && (i_mode == MODE_REMOVE) && (r_count != '0);

    // The chain of cells. Each sees its neighbours' links; the ends see fixed links.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (g == 0) begin : g_head
            assign w_left = LINK_HEAD;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = LINK_TAIL;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        mpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ins   (w_ins),
            .i_rem   (w_rem),
            .i_key   (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );

        assign w_valid_vec[g] = w_link[g].valid;
    end

    always_comb begin
        n_count = r_count;
        priority if (w_ins) begin
            n_count = r_count + CountW'(1);
        end else if (w_rem) begin
            n_count = r_count - CountW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_done     <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_done     <= w_accept;
            r_overflow <= w_accept && (i_mode == MODE_INSERT) && w_full;
        end
    end

    // The result reads the settled store directly, in the cycle after the beat.
    assign w_count_wide  = 32'(r_count);
    assign o_done        = r_done;
    assign o_is_empty    = (r_count == '0);
    assign o_top_value   = (r_count == '0) ? EMPTY_TOP : w_link[0].value;
    assign o_entry_count = w_count_wide[4:0];
    assign o_overflow    = r_overflow;

    `include "max_priority_queue_assert.svh"

    `MPQ_ASSERT_NEXT(a_done_follows, w_accept, r_done, "result strobe missing after a beat")
    `MPQ_ASSERT_NEXT(a_done_only, !w_accept, !r_done, "result strobe without a beat")
    `MPQ_ASSERT_IMP(a_ovf_full, r_overflow, r_count == CountW'(DEPTH), "overflow while not full")
    `MPQ_ASSERT_IMP(a_count_match, 1'b1, $countones(w_valid_vec) == r_count, "count mismatch")
    `MPQ_ASSERT_IMP(a_valid_prefix, 1'b1, ((w_valid_vec + DEPTH'(1)) & w_valid_vec) == '0, "gap")
    `MPQ_ASSERT_IMP(a_head_order, w_valid_vec[1], w_link[0].value >= w_link[1].value, "head order")

endmodule

@@ verif/max_priority_queue_tb.sv @@
// Self-checking testbench for the bounded max priority queue: directed rows, then random beats.
module max_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_BEATS = 1750;
    // Far above the slowest correct run: every beat waiting out the longest gap.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to wait after the last report before the final verdict.
    localparam int DRAIN_CYCLES = 4;

    // One report as the block shows it after a beat.
    typedef struct packed {
        logic signed [31:0] top_value;
        logic               is_empty;
        logic [4:0]         entry_count;
        logic               overflow;
    } t_queue_report;

    // A directed row. Where pinned is set, the report is typed in and is checked as given;
    // otherwise the report comes from the queue model.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic               pinned;
        t_queue_report      report;
    } t_directed_row;

    // Travels with each beat from the driver to the monitor.
    typedef struct packed {
        logic          pinned;
        t_queue_report report;
    } t_beat_note;

    // The directed part. It walks the store from empty through the extreme keys, shows that
    // a stored -1 is told apart from the empty store by the empty flag, removes from an empty
    // store (with all ones on the ignored key), then fills the store to the brim with repeated
    // and extreme keys and finally offers one more insert, which must be dropped and flagged.
    localparam int DIRECTED_ROWS = 25;
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_REMOVE, 32'sd0,          1'b1, '{EMPTY_TOP,       1'b1, 5'd0,  1'b0}},
        '{MODE_INSERT, 32'sh7FFF_FFFF,  1'b1, '{32'sh7FFF_FFFF,  1'b0, 5'd1,  1'b0}},
        '{MODE_INSERT, 32'sh8000_0000,  1'b1, '{32'sh7FFF_FFFF,  1'b0, 5'd2,  1'b0}},
        '{MODE_INSERT, 32'shFFFF_FFFF,  1'b1, '{32'sh7FFF_FFFF,  1'b0, 5'd3,  1'b0}},
        '{MODE_REMOVE, 32'sh1234_5678,  1'b1, '{32'shFFFF_FFFF,  1'b0, 5'd2,  1'b0}},
        '{MODE_REMOVE, 32'sd0,          1'b1, '{32'sh8000_0000,  1'b0, 5'd1,  1'b0}},
        '{MODE_REMOVE, 32'sd0,          1'b1, '{EMPTY_TOP,       1'b1, 5'd0,  1'b0}},
        '{MODE_REMOVE, 32'shFFFF_FFFF,  1'b1, '{EMPTY_TOP,       1'b1, 5'd0,  1'b0}},
        '{MODE_INSERT, 32'shFFFF_FFFF,  1'b1, '{32'shFFFF_FFFF,  1'b0, 5'd1,  1'b0}},
        '{MODE_INSERT, 32'sd5,          1'b0, '0},
        '{MODE_INSERT, 32'sd5,          1'b0, '0},
        '{MODE_INSERT, 32'sd0,          1'b0, '0},
        '{MODE_INSERT, 32'sh5555_5555,  1'b0, '0},
        '{MODE_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
        '{MODE_INSERT, 32'sd1,          1'b0, '0},
        '{MODE_INSERT, -32'sd2,         1'b0, '0},
        '{MODE_INSERT, 32'sh7FFF_FFFE,  1'b0, '0},
        '{MODE_INSERT, 32'sh8000_0001,  1'b0, '0},
        '{MODE_INSERT, 32'sd3,          1'b0, '0},
        '{MODE_INSERT, 32'sd3,          1'b0, '0},
        '{MODE_INSERT, 32'sd100,        1'b0, '0},
        '{MODE_INSERT, -32'sd100,       1'b0, '0},
        '{MODE_INSERT, -32'sd1,         1'b0, '0},
        '{MODE_INSERT, 32'sh7FFF_FFFF,  1'b0, '0},
        '{MODE_INSERT, 32'sd42,         1'b1, '{32'sh7FFF_FFFF,  1'b0, 5'd16, 1'b1}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = MODE_INSERT;
    logic signed [31:0] i_value = 32'sd0;
    logic               o_done;
    logic signed [31:0] o_top_value;
    logic               o_is_empty;
    logic [4:0]         o_entry_count;
    logic               o_overflow;

    // Model of the store: keys in descending order, the largest at the front.
    logic signed [31:0] model_keys[$];

    t_beat_note    beat_notes[$];
    t_queue_report awaited_reports[$];

    int mismatches = 0;
    int cycle_count = 0;
    int reports_checked = 0;
    int inserts_seen = 0;
    int removes_seen = 0;
    int dropped_inserts = 0;
    int removes_on_empty = 0;
    int times_full = 0;

    max_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_done       (o_done),
        .o_top_value  (o_top_value),
        .o_is_empty   (o_is_empty),
        .o_entry_count(o_entry_count),
        .o_overflow   (o_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one beat to the model and returns the report the block should show for it.
    // An insert goes behind every key that is equal to it, so equal keys leave in the
    // order they came; an insert into a full store is dropped and flagged, and a remove
    // from an empty store changes nothing.
    function automatic t_queue_report next_queue_report(input logic mode,
                                                        input logic signed [31:0] key);
        t_queue_report report;
        int            pos;

        report.overflow = 1'b0;
        if (mode == MODE_INSERT) begin
            inserts_seen++;
            if (model_keys.size() >= QUEUE_DEPTH) begin
                report.overflow = 1'b1;
                dropped_inserts++;
            end else begin
                pos = 0;
                while (pos < model_keys.size() && model_keys[pos] >= key)
                    pos++;
                model_keys.insert(pos, key);
                if (model_keys.size() == QUEUE_DEPTH)
                    times_full++;
            end
        end else begin
            removes_seen++;
            if (model_keys.size() == 0)
                removes_on_empty++;
            else
                void'(model_keys.pop_front());
        end
        report.top_value   = (model_keys.size() == 0) ? EMPTY_TOP : model_keys[0];
        report.is_empty    = (model_keys.size() == 0);
        report.entry_count = 5'(model_keys.size());
        return report;
    endfunction

    // The monitor. Everything is sampled at the rising edge, before the block's own updates
    // land, so a report is read in the cycle that ends at this edge and a beat is counted as
    // taken when start was high and busy low just before it. Reports are checked first,
    // then the beat taken at this edge queues its expectation.
    always @(posedge i_clk) begin : monitor
        t_queue_report got;
        t_queue_report want;
        t_queue_report modelled;
        t_beat_note    note;

        if (i_rst_n) begin
            if ($isunknown(o_done)) begin
                $error("o_done is unknown");
                mismatches++;
            end
            if (o_done === 1'b1) begin
                got = '{o_top_value, o_is_empty, o_entry_count, o_overflow};
                if (awaited_reports.size() == 0) begin
                    $error("report with no beat outstanding: top_value %0d count %0d",
                           got.top_value, got.entry_count);
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    reports_checked++;
                    if (got.top_value !== want.top_value) begin
                        $error("top_value: expected %0d, got %0d", want.top_value,
                               got.top_value);
                        mismatches++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0b, got %0b", want.is_empty,
                               got.is_empty);
                        mismatches++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", want.entry_count,
                               got.entry_count);
                        mismatches++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               got.overflow);
                        mismatches++;
                    end
                end
            end

            if (start && busy === 1'b0) begin
                modelled = next_queue_report(i_mode, i_value);
                if (beat_notes.size() == 0) begin
                    awaited_reports.push_back(modelled);
                end else begin
                    note = beat_notes.pop_front();
                    // A typed-in report replaces the modelled one; the model still advances.
                    awaited_reports.push_back(note.pinned ? note.report : modelled);
                end
            end
        end
    end

    // Ends the run if it has not finished well within the limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d reports outstanding", cycle_count,
                     awaited_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one beat and holds it until it is taken, then leaves start low for the gap.
    // The caller stands at a rising edge; with no gap the next beat follows straight on,
    // so start simply stays high.
    task automatic issue_beat(input logic mode, input logic signed [31:0] key,
                              input logic pinned, input t_queue_report report,
                              input int gap);
        beat_notes.push_back('{pinned, report});
        i_mode  <= mode;
        i_value <= key;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap(input bit quiet);
        int roll;

        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Keys are drawn from a narrow band around zero so that equal keys meet often, from the
    // extremes, and from the whole range so that every bit toggles.
    function automatic logic signed [31:0] pick_key();
        int roll;

        roll = $urandom_range(0, 9);
        if (roll < 4)
            return 32'($signed($urandom_range(0, 8)) - 4);
        if (roll == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    initial begin : stimulus
        int         sent;
        int         burst_len;
        int         insert_pct;
        bit         quiet;
        logic       mode;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
            issue_beat(DIRECTED[row].mode, DIRECTED[row].value, DIRECTED[row].pinned,
                       DIRECTED[row].report, pick_gap(row < 12));

        // Random bursts. Each burst leans towards inserts, towards removes or neither, so the
        // store keeps swinging between full and empty and both the dropped insert and the
        // remove on an empty store come up again and again. Some bursts run with no gaps.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst_len && sent < RANDOM_BEATS; k++) begin
                mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                issue_beat(mode, pick_key(), 1'b0, '0, pick_gap(quiet));
                sent++;
            end
        end

        start <= 1'b0;
        while (awaited_reports.size() != 0 || beat_notes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (awaited_reports.size() != 0) begin
            $error("%0d expected reports never arrived", awaited_reports.size());
            mismatches++;
        end

        $display("Checked %0d reports: %0d inserts (%0d dropped on a full queue), %0d removes",
                 reports_checked, inserts_seen, dropped_inserts, removes_seen);
        $display("Removes on an empty queue: %0d; queue filled to the brim %0d times",
                 removes_on_empty, times_full);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
